@@ rtl/core/csap_pkg.sv @@
// ----------------------------------------------------------------------------
// csap_pkg: color string attribute parser package
// Shared constants, coding tables and helper functions for the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csap_pkg;

  // Default geometry
  localparam int unsigned SLOT_COUNT_DEF = 32;
  localparam int unsigned TOKEN_MAX_DEF  = 8;

  // Field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned TLEN_W  = 4;
  localparam int unsigned ACC_W   = 4;
  localparam int unsigned DIG_W   = 7;
  localparam int unsigned PAIR_W  = 4;
  localparam int unsigned ATTR_W  = 16;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // Slot addresses reachable from a pair index: 2*idx and 2*idx+1
  localparam int unsigned PAIR_SLOTS = 2 ** (PAIR_W + 1);

  // Register map (word select bit of paddr)
  localparam logic REG_PAIR_IDX = 1'b0;
  localparam logic REG_EXT_MODE = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_THREE = 8'h33;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_B     = 8'h42;
  localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h52;
  localparam logic [CHAR_W-1:0] CH_W     = 8'h57;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;

  // Extended color flag
  localparam logic [SLOT_W-1:0] FLAG_EXT = 8'h80;

  // Legacy color to extended color
  localparam logic [DIG_W-1:0] LEG_TO_EXT [16] = '{
    7'd0, 7'd4, 7'd16, 7'd20, 7'd64, 7'd68, 7'd80, 7'd126,
    7'd43, 7'd7, 7'd25, 7'd31, 7'd97, 7'd103, 7'd121, 7'd127
  };

  // Extended color (flag stripped) to legacy color
  localparam logic [ACC_W-1:0] EXT_TO_LEG [128] = '{
    4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd9, 4'd9, 4'd9,
    4'd2, 4'd2, 4'd3, 4'd3, 4'd1, 4'd9, 4'd9, 4'd9,
    4'd2, 4'd10, 4'd2, 4'd10, 4'd3, 4'd11, 4'd9, 4'd9,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11,
    4'd4, 4'd4, 4'd5, 4'd5, 4'd1, 4'd9, 4'd9, 4'd9,
    4'd6, 4'd6, 4'd8, 4'd8, 4'd1, 4'd9, 4'd9, 4'd9,
    4'd2, 4'd10, 4'd2, 4'd10, 4'd3, 4'd11, 4'd9, 4'd9,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11,
    4'd4, 4'd12, 4'd4, 4'd12, 4'd5, 4'd13, 4'd9, 4'd9,
    4'd4, 4'd12, 4'd4, 4'd12, 4'd5, 4'd13, 4'd9, 4'd9,
    4'd6, 4'd14, 4'd6, 4'd14, 4'd7, 4'd7, 4'd9, 4'd9,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11,
    4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd13, 4'd13,
    4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd13, 4'd13,
    4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd13, 4'd13,
    4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd7, 4'd15
  };

  // Slot contents after reset; slots past the table hold zero
  localparam int unsigned SLOT_DEF_N = 14;
  localparam logic [SLOT_W-1:0] SLOT_DEFAULT [SLOT_DEF_N] = '{
    8'd7, 8'd0, 8'd0, 8'd7, 8'd7, 8'd0, 8'd7,
    8'd0, 8'd7, 8'd0, 8'd7, 8'd0, 8'd7, 8'd0
  };

  // Reset value of a slot (address zero-extended to 6 bits)
  function automatic logic [SLOT_W-1:0] slot_default(input logic [5:0] addr);
    logic [SLOT_W-1:0] val;
    val = '0;
    if (addr < 6'(SLOT_DEF_N)) begin
      val = SLOT_DEFAULT[addr[3:0]];
    end
    return val;
  endfunction

  // Color value of a finished token
  function automatic logic [SLOT_W-1:0] token_value(
    input logic [TLEN_W-1:0] len,
    input logic [CHAR_W-1:0] first,
    input logic [ACC_W-1:0]  acc,
    input logic [DIG_W-1:0]  dig
  );
    logic [SLOT_W-1:0] val;
    if ((len != '0) && (first > CH_THREE)) begin
      val = {4'b0, acc};
    end else begin
      val = {1'b1, dig};
    end
    return val;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/csap_ram.sv @@
// ----------------------------------------------------------------------------
// csap_ram: generic RAM
// One write port, two read ports with registered read data and read enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write and registered read (read returns the old contents)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

@@ rtl/core/color_string_attr_parser.sv @@
// Pipeline: a last character gives its result after passing the input register,
//   the slot RAM read and the attribute register.
// Throughput: one character per cycle; a token write stalls while an empty slot is
//   queued for the slot RAM write port, a last character while the output stalls.
// Reset: asynchronous, active low; slots read as their defaults until written
//   (per-slot valid bits), pair index 0, extended mode on.
// ----------------------------------------------------------------------------
// color_string_attr_parser: color string attribute parser
// Tokenizes a color string into color slots and returns the text attribute of
// the configured foreground/background slot pair at the end of each string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module color_string_attr_parser #(
  parameter int unsigned SLOT_COUNT = csap_pkg::SLOT_COUNT_DEF,
  parameter int unsigned TOKEN_MAX  = csap_pkg::TOKEN_MAX_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [csap_pkg::APB_AW-1:0]   paddr,
  input  wire logic [csap_pkg::APB_DW-1:0]   pwdata,
  output logic      [csap_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  // character input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [csap_pkg::CHAR_W-1:0]   char_code_i,
  input  wire logic                          last_char_i,
  // attribute output
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [csap_pkg::ATTR_W-1:0]   text_attr_o,
  output logic                               attr_is_extended_o
);

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned PW = $clog2(SLOT_COUNT + 1);

  localparam logic [PW:0]   SLOT_END = (PW + 1)'(SLOT_COUNT);
  localparam logic [csap_pkg::TLEN_W-1:0] TLEN_MAX = csap_pkg::TLEN_W'(TOKEN_MAX);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [csap_pkg::PAIR_W-1:0] pair_idx_q;
  logic                        ext_mode_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_idx_q <= '0;
      ext_mode_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        csap_pkg::REG_PAIR_IDX: pair_idx_q <= pwdata[csap_pkg::PAIR_W-1:0];
        csap_pkg::REG_EXT_MODE: ext_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      csap_pkg::REG_PAIR_IDX: prdata = {{(csap_pkg::APB_DW - csap_pkg::PAIR_W){1'b0}},
                                        pair_idx_q};
      csap_pkg::REG_EXT_MODE: prdata = {{(csap_pkg::APB_DW - 1){1'b0}}, ext_mode_q};
      default:                prdata = '0;
    endcase
  end

  // Pair slot addresses, folded modulo the slot count at elaboration
  logic [AW-1:0] pair_map [csap_pkg::PAIR_SLOTS];
  logic [AW-1:0] fg_addr;
  logic [AW-1:0] bg_addr;

  for (genvar gi = 0; gi < csap_pkg::PAIR_SLOTS; gi++) begin : g_pair_map
    assign pair_map[gi] = AW'(gi % SLOT_COUNT);
  end

  assign fg_addr = pair_map[{pair_idx_q, 1'b0}];
  assign bg_addr = pair_map[{pair_idx_q, 1'b1}];

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                        s1_v_q;
  logic [csap_pkg::CHAR_W-1:0] s1_char_q;
  logic                        s1_last_q;
  logic                        s1_go;
  logic                        in_take;

  assign in_stall_o = s1_v_q & ~s1_go;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_take) begin
      s1_v_q <= 1'b1;
    end else if (s1_go) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= char_code_i;
      s1_last_q <= last_char_i;
    end
  end

  // --------------------------------------------------------------------------
  // Tokenizer state
  // --------------------------------------------------------------------------
  logic [PW-1:0]                 pos_q, pos_d;
  logic [csap_pkg::TLEN_W-1:0]   tlen_q, tlen_d;
  logic [csap_pkg::CHAR_W-1:0]   first_q, first_d;
  logic [csap_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [csap_pkg::DIG_W-1:0]    dig_q, dig_d;

  // token with the current character added
  logic [csap_pkg::CHAR_W-1:0]   up_char;
  logic [csap_pkg::TLEN_W-1:0]   add_len;
  logic [csap_pkg::CHAR_W-1:0]   add_first;
  logic [csap_pkg::ACC_W-1:0]    add_acc;
  logic [csap_pkg::DIG_W-1:0]    add_dig;

  // slot writes caused by this character
  logic                          w1_en;
  logic [csap_pkg::SLOT_W-1:0]   w1_data;
  logic                          w2_en;
  logic [AW-1:0]                 w2_addr;

  logic                          active;
  logic                          is_comma;
  logic                          is_delim;
  logic [PW:0]                   sum1, sum2;
  logic [PW-1:0]                 adv1, adv2, adv;

  // Add one character to the token being built
  always_comb begin
    up_char = s1_char_q;
    if ((s1_char_q >= csap_pkg::CH_LOW_A) && (s1_char_q <= csap_pkg::CH_LOW_Z)) begin
      up_char = s1_char_q - csap_pkg::CH_CASE;
    end
    add_len   = tlen_q + 1'b1;
    add_first = (tlen_q == '0) ? s1_char_q : first_q;
    add_acc   = acc_q;
    unique case (up_char)
      csap_pkg::CH_B:    add_acc = acc_q | 4'd1;
      csap_pkg::CH_G:    add_acc = acc_q | 4'd2;
      csap_pkg::CH_R:    add_acc = acc_q | 4'd4;
      csap_pkg::CH_W:    add_acc = acc_q | 4'd7;
      csap_pkg::CH_PLUS: add_acc = acc_q | 4'd8;
      default:           add_acc = acc_q;
    endcase
    add_dig = dig_q;
    unique case (tlen_q)
      4'd0:    add_dig[6:5] = dig_q[6:5] | s1_char_q[1:0];
      4'd1:    add_dig[4:3] = dig_q[4:3] | s1_char_q[1:0];
      4'd2:    add_dig[2:1] = dig_q[2:1] | s1_char_q[1:0];
      4'd3:    add_dig[0]   = dig_q[0]   | s1_char_q[0];
      default: add_dig = dig_q;
    endcase
  end

  // Saturating slot advance
  assign sum1 = {1'b0, pos_q} + (PW + 1)'(1);
  assign sum2 = {1'b0, pos_q} + (PW + 1)'(2);
  assign adv1 = (sum1 > SLOT_END) ? SLOT_END[PW-1:0] : sum1[PW-1:0];
  assign adv2 = (sum2 > SLOT_END) ? SLOT_END[PW-1:0] : sum2[PW-1:0];

  assign active   = ({1'b0, pos_q} < SLOT_END);
  assign is_comma = (s1_char_q == csap_pkg::CH_COMMA);
  assign is_delim = is_comma | (s1_char_q == csap_pkg::CH_SLASH);

  // Token step: next state and slot writes
  always_comb begin
    pos_d   = pos_q;
    tlen_d  = tlen_q;
    first_d = first_q;
    acc_d   = acc_q;
    dig_d   = dig_q;
    w1_en   = 1'b0;
    w1_data = csap_pkg::token_value(tlen_q, first_q, acc_q, dig_q);
    w2_en   = 1'b0;
    adv     = adv1;
    if (active) begin
      if (is_delim) begin
        // close the token; a comma after an even slot skips one
        w1_en  = 1'b1;
        adv    = (is_comma && !pos_q[0]) ? adv2 : adv1;
        pos_d  = adv;
        tlen_d = '0; first_d = '0; acc_d = '0; dig_d = '0;
        w2_en  = s1_last_q && ({1'b0, adv} < SLOT_END);
      end else if (s1_char_q == csap_pkg::CH_SPACE) begin
        w1_en = s1_last_q;
      end else begin
        w1_data = csap_pkg::token_value(add_len, add_first, add_acc, add_dig);
        if (add_len >= TLEN_MAX) begin
          // token full: close it
          w1_en  = 1'b1;
          pos_d  = adv1;
          tlen_d = '0; first_d = '0; acc_d = '0; dig_d = '0;
          w2_en  = s1_last_q && ({1'b0, adv1} < SLOT_END);
        end else begin
          w1_en   = s1_last_q;
          tlen_d  = add_len;
          first_d = add_first;
          acc_d   = add_acc;
          dig_d   = add_dig;
        end
      end
    end
    // end of string: start over
    if (s1_last_q) begin
      pos_d = '0; tlen_d = '0; first_d = '0; acc_d = '0; dig_d = '0;
    end
  end

  assign w2_addr = adv[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      tlen_q  <= '0;
      first_q <= '0;
      acc_q   <= '0;
      dig_q   <= '0;
    end else if (s1_go) begin
      pos_q   <= pos_d;
      tlen_q  <= tlen_d;
      first_q <= first_d;
      acc_q   <= acc_d;
      dig_q   <= dig_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic s2_v_q;
  logic out_v_q;
  logic out_ready;
  logic s2_ready;
  logic pend_v_q;
  logic [AW-1:0] pend_addr_q;

  assign out_ready = ~out_v_q | ~out_stall_i;
  assign s2_ready  = ~s2_v_q | out_ready;
  // a token write waits while a queued empty slot drains
  assign s1_go     = s1_v_q & (~s1_last_q | s2_ready) & ~(pend_v_q & w1_en);

  // --------------------------------------------------------------------------
  // Slot RAM write port and queued empty slot
  // --------------------------------------------------------------------------
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [csap_pkg::SLOT_W-1:0] ram_wdata;
  logic                        tok_wr;
  logic [SLOT_COUNT-1:0]       vld_q;

  assign tok_wr    = s1_go & w1_en;
  assign ram_we    = tok_wr | pend_v_q;
  assign ram_waddr = tok_wr ? pos_q[AW-1:0] : pend_addr_q;
  assign ram_wdata = tok_wr ? w1_data : csap_pkg::FLAG_EXT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      pend_v_q <= s1_go & w2_en;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && w2_en) begin
      pend_addr_q <= w2_addr;
    end
  end

  // --------------------------------------------------------------------------
  // Pair read with forwarding of this cycle's writes
  // --------------------------------------------------------------------------
  logic                        rd_en;
  logic [csap_pkg::SLOT_W-1:0] ram_a, ram_b;
  logic                        use_a, use_b;
  logic [csap_pkg::SLOT_W-1:0] fb_a, fb_b;
  logic                        s2_use_a_q, s2_use_b_q;
  logic [csap_pkg::SLOT_W-1:0] s2_fb_a_q, s2_fb_b_q;

  assign rd_en = s1_go & s1_last_q;

  csap_ram #(
    .WIDTH (csap_pkg::SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (rd_en),
    .raddr_a_i (fg_addr),
    .raddr_b_i (bg_addr),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // newest write wins: empty slot, token, queued empty slot, then RAM or slot default
  always_comb begin
    use_a = 1'b0;
    fb_a  = csap_pkg::FLAG_EXT;
    if (w2_en && (w2_addr == fg_addr)) begin
      fb_a = csap_pkg::FLAG_EXT;
    end else if (w1_en && (pos_q[AW-1:0] == fg_addr)) begin
      fb_a = w1_data;
    end else if (pend_v_q && (pend_addr_q == fg_addr)) begin
      fb_a = csap_pkg::FLAG_EXT;
    end else begin
      use_a = vld_q[fg_addr];
      fb_a  = csap_pkg::slot_default(6'(fg_addr));
    end
  end

  always_comb begin
    use_b = 1'b0;
    fb_b  = csap_pkg::FLAG_EXT;
    if (w2_en && (w2_addr == bg_addr)) begin
      fb_b = csap_pkg::FLAG_EXT;
    end else if (w1_en && (pos_q[AW-1:0] == bg_addr)) begin
      fb_b = w1_data;
    end else if (pend_v_q && (pend_addr_q == bg_addr)) begin
      fb_b = csap_pkg::FLAG_EXT;
    end else begin
      use_b = vld_q[bg_addr];
      fb_b  = csap_pkg::slot_default(6'(bg_addr));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (rd_en) begin
      s2_v_q <= 1'b1;
    end else if (out_ready) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s2_use_a_q <= use_a;
      s2_use_b_q <= use_b;
      s2_fb_a_q  <= fb_a;
      s2_fb_b_q  <= fb_b;
    end
  end

  // --------------------------------------------------------------------------
  // Attribute from the color pair
  // --------------------------------------------------------------------------
  logic [csap_pkg::SLOT_W-1:0] x1, x2;
  logic [csap_pkg::SLOT_W-1:0] n1, n2;
  logic [csap_pkg::ATTR_W-1:0] attr_d;
  logic                        ext_d;
  logic [csap_pkg::ATTR_W-1:0] text_attr_q;
  logic                        attr_ext_q;

  assign x1 = s2_use_a_q ? ram_a : s2_fb_a_q;
  assign x2 = s2_use_b_q ? ram_b : s2_fb_b_q;

  always_comb begin
    ext_d = x1[7] | x2[7];
    n1    = x1;
    n2    = x2;
    if (ext_d && ext_mode_q) begin
      // widen legacy colors
      if (!x1[7]) n1 = {1'b1, csap_pkg::LEG_TO_EXT[x1[3:0]]};
      if (!x2[7]) n2 = {1'b1, csap_pkg::LEG_TO_EXT[x2[3:0]]};
      attr_d = {n2, n1};
    end else begin
      // narrow extended colors
      if (x1[7]) n1 = {4'b0, csap_pkg::EXT_TO_LEG[x1[6:0]]};
      if (x2[7]) n2 = {4'b0, csap_pkg::EXT_TO_LEG[x2[6:0]]};
      attr_d = {8'b0, n1} + {4'b0, n2, 4'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_v_q) begin
      text_attr_q <= attr_d;
      attr_ext_q  <= ext_d;
    end
  end

  assign out_valid_o        = out_v_q;
  assign text_attr_o        = text_attr_q;
  assign attr_is_extended_o = attr_ext_q;

endmodule

`default_nettype wire
